// File: rtl/gpj_pkg.sv
// Shared types and constants of the game port joystick digitizer.
// No dependencies; every other file of the block imports it.
package gpj_pkg;

    localparam int C_CNT_W       = 17;
    localparam int C_COUNT_LIMIT = 65536;
    localparam int C_PORT_W      = 8;

    // Game port bit positions; buttons are active low
    localparam int C_BIT_X     = 0;
    localparam int C_BIT_Y     = 1;
    localparam int C_BIT_BTN_A = 4;
    localparam int C_BIT_BTN_B = 5;

    // floor(n / 3) == (n * C_RECIP_3) >> C_RECIP_SHIFT for every n below 2**17
    localparam int                 C_RECIP_W     = 16;
    localparam int                 C_RECIP_SHIFT = 17;
    localparam logic [C_RECIP_W-1:0] C_RECIP_3   = 16'd43691;

    typedef logic [C_CNT_W-1:0]  t_cnt;
    typedef logic [C_PORT_W-1:0] t_port;

    // End of one measurement: final counts and latched buttons
    typedef struct packed {
        t_cnt       x_count;
        t_cnt       y_count;
        logic       fire_a;
        logic       fire_b;
        logic       timed_out;
    } t_meas;

    // After calibration update: offsets and calibrated range per axis
    typedef struct packed {
        t_cnt       x_offset;
        t_cnt       y_offset;
        t_cnt       x_range;
        t_cnt       y_range;
        logic       fire_a;
        logic       fire_b;
        logic       timed_out;
    } t_calib;

    typedef struct packed {
        logic       left;
        logic       right;
        logic       up;
        logic       down;
        logic       fire_a;
        logic       fire_b;
        t_cnt       x_offset;
        t_cnt       y_offset;
        logic       timed_out;
    } t_result;

endpackage

// File: rtl/gpj_if.sv
// Valid/ready channel interfaces of the joystick digitizer: samples in,
// results out, and the sample limit write port. Depends on gpj_pkg.
interface gpj_in_if
    import gpj_pkg::*;
();
    logic  valid;
    logic  ready;
    logic  start_req;
    t_port port_sample;

    modport source (output valid, output start_req, output port_sample, input ready);
    modport sink   (input valid, input start_req, input port_sample, output ready);
endinterface

interface gpj_out_if
    import gpj_pkg::*;
();
    logic valid;
    logic ready;
    logic left;
    logic right;
    logic up;
    logic down;
    logic fire_a;
    logic fire_b;
    t_cnt x_offset;
    t_cnt y_offset;
    logic timed_out;

    modport source (output valid, output left, output right, output up, output down,
                    output fire_a, output fire_b, output x_offset, output y_offset,
                    output timed_out, input ready);
    modport sink   (input valid, input left, input right, input up, input down,
                    input fire_a, input fire_b, input x_offset, input y_offset,
                    input timed_out, output ready);
endinterface

interface gpj_cfg_if
    import gpj_pkg::*;
();
    logic valid;
    logic ready;
    t_cnt data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/game_port_joystick_digitizer_core.sv
// Top level of the game port joystick digitizer: limit register and the
// timer, calibration and direction stages. Depends on gpj_pkg and gpj_if.

// Feed one game port sample per cycle; a start transaction fires the one-shots
// and latches the buttons, later samples count the X/Y timer bits. The block
// takes a sample in every cycle unless the input is stalled. The measurement
// ends on a sample with both timer bits low, or at the sample limit. Results
// pass through three registered stages (count, calibrate, classify), each
// with its own valid bit, so a waiting result does not stop sampling until
// all three stages are full. Calibration keeps a running min/max per axis
// from reset. The sample limit is written through the configuration channel,
// 0 acting as 1 and values above the count limit acting as the limit; the user
// must write it only while no measurement is running, which is not enforced.
module game_port_joystick_digitizer_core
    import gpj_pkg::*;
#(
    parameter int P_COUNT_LIMIT = C_COUNT_LIMIT
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    gpj_in_if.sink            i_in,
    gpj_out_if.source         o_out,
    gpj_cfg_if.sink           i_cfg
);

    t_cnt    r_eff_limit;
    t_cnt    n_eff_limit;
    logic    s1_valid, s1_ready;
    t_meas   s1_meas;
    logic    s2_valid, s2_ready;
    t_calib  s2_calib;
    t_result result;

    assign i_cfg.ready = 1'b1;

    // Clamp once on write so the timer compares against a ready value
    always_comb begin
        n_eff_limit = i_cfg.data;
        if (i_cfg.data == '0) begin
            n_eff_limit = t_cnt'(1);
        end else if (i_cfg.data > t_cnt'(P_COUNT_LIMIT)) begin
            n_eff_limit = t_cnt'(P_COUNT_LIMIT);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_eff_limit <= t_cnt'(P_COUNT_LIMIT);
        end else if (i_cfg.valid) begin
            r_eff_limit <= n_eff_limit;
        end
    end

    gpj_timer u_timer (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_in.valid),
        .o_ready       (i_in.ready),
        .i_start_req   (i_in.start_req),
        .i_port_sample (i_in.port_sample),
        .i_eff_limit   (r_eff_limit),
        .o_valid       (s1_valid),
        .i_ready       (s1_ready),
        .o_meas        (s1_meas)
    );

    gpj_calib #(
        .P_COUNT_LIMIT (P_COUNT_LIMIT)
    ) u_calib (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s1_valid),
        .o_ready (s1_ready),
        .i_meas  (s1_meas),
        .o_valid (s2_valid),
        .i_ready (s2_ready),
        .o_calib (s2_calib)
    );

    gpj_classify u_classify (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (s2_valid),
        .o_ready  (s2_ready),
        .i_calib  (s2_calib),
        .o_valid  (o_out.valid),
        .i_ready  (o_out.ready),
        .o_result (result)
    );

    assign o_out.left      = result.left;
    assign o_out.right     = result.right;
    assign o_out.up        = result.up;
    assign o_out.down      = result.down;
    assign o_out.fire_a    = result.fire_a;
    assign o_out.fire_b    = result.fire_b;
    assign o_out.x_offset  = result.x_offset;
    assign o_out.y_offset  = result.y_offset;
    assign o_out.timed_out = result.timed_out;

    a_dir_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> !(o_out.left && o_out.right) && !(o_out.up && o_out.down))
        else $error("opposite directions both set");

    a_stall_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in.ready |-> s1_valid && s2_valid && o_out.valid)
        else $error("sample input stalled with a free stage");

    a_offset_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (o_out.x_offset <= t_cnt'(P_COUNT_LIMIT))
                     && (o_out.y_offset <= t_cnt'(P_COUNT_LIMIT)))
        else $error("axis offset beyond count limit");

    a_result_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s2_valid && s2_ready |=> o_out.valid)
        else $error("calibrated transaction lost before result register");

endmodule

// File: rtl/gpj_timer.sv
// One-shot timing stage: counts X/Y timer bits per sample and registers the
// finished measurement. Depends on gpj_pkg.
module gpj_timer
    import gpj_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_ready,
    input  logic  i_start_req,
    input  t_port i_port_sample,
    input  t_cnt  i_eff_limit,
    output logic  o_valid,
    input  logic  i_ready,
    output t_meas o_meas
);

    logic       r_measuring, n_measuring;
    t_cnt       r_counter, n_counter;
    t_cnt       r_x_count, n_x_count;
    t_cnt       r_y_count, n_y_count;
    logic [1:0] r_buttons, n_buttons;
    logic       r_valid;
    t_meas      r_meas;

    logic       accept;
    logic       both_low;
    logic       finish;

    assign o_ready = !r_valid || i_ready;
    assign accept  = i_valid && o_ready;
    assign both_low = !i_port_sample[C_BIT_X] && !i_port_sample[C_BIT_Y];

    always_comb begin
        n_measuring = r_measuring;
        n_counter   = r_counter;
        n_x_count   = r_x_count;
        n_y_count   = r_y_count;
        n_buttons   = r_buttons;
        finish      = 1'b0;
        if (accept) begin
            if (i_start_req) begin
                n_buttons   = {!i_port_sample[C_BIT_BTN_B], !i_port_sample[C_BIT_BTN_A]};
                n_measuring = 1'b1;
                n_counter   = '0;
                n_x_count   = '0;
                n_y_count   = '0;
            end else if (r_measuring) begin
                n_x_count = r_x_count + t_cnt'(i_port_sample[C_BIT_X]);
                n_y_count = r_y_count + t_cnt'(i_port_sample[C_BIT_Y]);
                n_counter = r_counter + t_cnt'(1);
                if (both_low || (n_counter >= i_eff_limit)) begin
                    finish      = 1'b1;
                    n_measuring = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_measuring <= 1'b0;
            r_counter   <= '0;
            r_x_count   <= '0;
            r_y_count   <= '0;
            r_buttons   <= '0;
            r_valid     <= 1'b0;
        end else begin
            r_measuring <= n_measuring;
            r_counter   <= n_counter;
            r_x_count   <= n_x_count;
            r_y_count   <= n_y_count;
            r_buttons   <= n_buttons;
            if (finish) begin
                r_valid <= 1'b1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (finish) begin
            r_meas.x_count   <= n_x_count;
            r_meas.y_count   <= n_y_count;
            r_meas.fire_a    <= r_buttons[0];
            r_meas.fire_b    <= r_buttons[1];
            r_meas.timed_out <= !both_low;
        end
    end

    assign o_valid = r_valid;
    assign o_meas  = r_meas;

endmodule

// File: rtl/gpj_calib.sv
// Calibration stage: tracks running min/max per axis and registers offsets
// and calibrated ranges. Depends on gpj_pkg.
module gpj_calib
    import gpj_pkg::*;
#(
    parameter int P_COUNT_LIMIT = C_COUNT_LIMIT
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_valid,
    output logic   o_ready,
    input  t_meas  i_meas,
    output logic   o_valid,
    input  logic   i_ready,
    output t_calib o_calib
);

    t_cnt   r_x_min, n_x_min;
    t_cnt   r_x_max, n_x_max;
    t_cnt   r_y_min, n_y_min;
    t_cnt   r_y_max, n_y_max;
    logic   r_valid;
    t_calib r_calib;
    logic   accept;

    assign o_ready = !r_valid || i_ready;
    assign accept  = i_valid && o_ready;

    always_comb begin
        n_x_max = (i_meas.x_count > r_x_max) ? i_meas.x_count : r_x_max;
        n_x_min = (i_meas.x_count < r_x_min) ? i_meas.x_count : r_x_min;
        n_y_max = (i_meas.y_count > r_y_max) ? i_meas.y_count : r_y_max;
        n_y_min = (i_meas.y_count < r_y_min) ? i_meas.y_count : r_y_min;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x_min <= t_cnt'(P_COUNT_LIMIT);
            r_x_max <= '0;
            r_y_min <= t_cnt'(P_COUNT_LIMIT);
            r_y_max <= '0;
            r_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_x_min <= n_x_min;
                r_x_max <= n_x_max;
                r_y_min <= n_y_min;
                r_y_max <= n_y_max;
                r_valid <= 1'b1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_calib.x_offset  <= i_meas.x_count - n_x_min;
            r_calib.y_offset  <= i_meas.y_count - n_y_min;
            r_calib.x_range   <= n_x_max - n_x_min;
            r_calib.y_range   <= n_y_max - n_y_min;
            r_calib.fire_a    <= i_meas.fire_a;
            r_calib.fire_b    <= i_meas.fire_b;
            r_calib.timed_out <= i_meas.timed_out;
        end
    end

    assign o_valid = r_valid;
    assign o_calib = r_calib;

endmodule

// File: rtl/gpj_classify.sv
// Direction stage: splits each range into thirds by reciprocal multiply and
// holds the result register. Depends on gpj_pkg.
module gpj_classify
    import gpj_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    output logic    o_ready,
    input  t_calib  i_calib,
    output logic    o_valid,
    input  logic    i_ready,
    output t_result o_result
);

    localparam int C_PROD_W = C_CNT_W + C_RECIP_W;

    logic [C_PROD_W-1:0] x_prod, y_prod;
    t_cnt                x_third, y_third;
    t_cnt                x_two, y_two;
    logic                r_valid;
    t_result             r_result;
    logic                accept;

    assign o_ready = !r_valid || i_ready;
    assign accept  = i_valid && o_ready;

    assign x_prod  = C_PROD_W'(i_calib.x_range) * C_PROD_W'(C_RECIP_3);
    assign y_prod  = C_PROD_W'(i_calib.y_range) * C_PROD_W'(C_RECIP_3);
    assign x_third = t_cnt'(x_prod[C_PROD_W-1:C_RECIP_SHIFT]);
    assign y_third = t_cnt'(y_prod[C_PROD_W-1:C_RECIP_SHIFT]);
    assign x_two   = x_third << 1;
    assign y_two   = y_third << 1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_result.left      <= i_calib.x_offset < x_third;
            r_result.right     <= i_calib.x_offset > x_two;
            r_result.up        <= i_calib.y_offset < y_third;
            r_result.down      <= i_calib.y_offset > y_two;
            r_result.fire_a    <= i_calib.fire_a;
            r_result.fire_b    <= i_calib.fire_b;
            r_result.x_offset  <= i_calib.x_offset;
            r_result.y_offset  <= i_calib.y_offset;
            r_result.timed_out <= i_calib.timed_out;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule
